FILE: hw/rtl/scle_pkg.sv
`default_nettype none

package scle_pkg;

  // store geometry
  localparam int unsigned LINE_DEPTH   = 32;
  localparam int unsigned ANSWER_DEPTH = 32;
  localparam int unsigned LINE_AW      = $clog2(LINE_DEPTH);
  localparam int unsigned ANSWER_AW    = $clog2(ANSWER_DEPTH);

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned LEN_W  = 6;

  // special characters
  localparam logic [BYTE_W-1:0] CHAR_DEL = 8'd127;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;

  // request kinds
  typedef enum logic [2:0] {
    MODE_RX_BYTE   = 3'd0,
    MODE_TX_DONE   = 3'd1,
    MODE_START_ANS = 3'd2,
    MODE_WRITE_ANS = 3'd3,
    MODE_READ_LINE = 3'd4,
    MODE_SET_COUNT = 3'd5
  } mode_e;

  // engine states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RECV  = 2'd1,
    ST_READY = 2'd2,
    ST_SEND  = 2'd3
  } engine_state_e;

  // result of one request, waiting for the store read data
  typedef struct packed {
    logic              send_valid;
    logic              use_answer;
    logic [BYTE_W-1:0] echo_byte;
    logic              line_ready;
    logic              sending;
    logic [LEN_W-1:0]  line_length;
    logic              read_line;
  } pend_t;

endpackage

`default_nettype wire

FILE: hw/rtl/serial_command_line_engine.sv
// a result passes the pending stage and then the output register before it leaves
// throughput: one request per cycle while not stalled, each request does at most one read and one write per store
// the input stalls only while the result side holds off with both stages full
// reset clears the engine state, the line count and the answer pointers;
// the line and answer stores are not cleared and hold garbage until written
`default_nettype none

module serial_command_line_engine
  import scle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // data_byte [7:0], entry_index [12:8], length_value [18:13], zero [23:19]
  input  wire logic [23:0] s_axis_tdata_i,
  // mode [2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // send_valid [0], send_byte [8:1], line_ready [9], sending [10],
  // line_length [16:11], read_byte [24:17], zero [31:25]
  output logic [31:0]      m_axis_tdata_o
);

  // request fields
  logic [BYTE_W-1:0] in_byte;
  logic [IDX_W-1:0]  in_idx;
  logic [LEN_W-1:0]  in_len;
  logic              in_acc;

  assign in_byte = s_axis_tdata_i[7:0];
  assign in_idx  = s_axis_tdata_i[12:8];
  assign in_len  = s_axis_tdata_i[18:13];

  // control registers
  engine_state_e    state_q, state_d;
  logic [LEN_W-1:0] line_cnt_q, line_cnt_d;
  logic [LEN_W-1:0] ans_pos_q, ans_pos_d;
  logic [LEN_W-1:0] ans_len_q, ans_len_d;

  // pipeline registers
  logic             pend_vld_q;
  pend_t            pend_q, pend_d;
  logic             out_vld_q;
  logic [31:0]      out_data_q;
  logic             pend_move;

  // store ports
  logic                 line_we, line_re;
  logic [LINE_AW-1:0]   line_waddr, line_raddr;
  logic [BYTE_W-1:0]    line_rdata;
  logic                 ans_we, ans_re;
  logic [ANSWER_AW-1:0] ans_waddr, ans_raddr;
  logic [BYTE_W-1:0]    ans_rdata;

  logic [LEN_W-1:0] pos_inc;

  // handshake: the pending stage moves on whenever the output register frees up
  assign pend_move       = pend_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !pend_vld_q || pend_move;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_inc         = ans_pos_q + LEN_W'(1);

  // request decode and next control state
  always_comb begin
    state_d    = state_q;
    line_cnt_d = line_cnt_q;
    ans_pos_d  = ans_pos_q;
    ans_len_d  = ans_len_q;
    line_we    = 1'b0;
    line_waddr = line_cnt_q[LINE_AW-1:0];
    line_re    = 1'b0;
    line_raddr = in_idx[LINE_AW-1:0];
    ans_we     = 1'b0;
    ans_waddr  = in_idx[ANSWER_AW-1:0];
    ans_re     = 1'b0;
    ans_raddr  = pos_inc[ANSWER_AW-1:0];
    pend_d     = '0;

    unique case (s_axis_tuser_i)
      MODE_RX_BYTE: begin
        if (state_q != ST_SEND) begin
          if (in_byte == CHAR_DEL) begin
            // delete only echoes when something was removed
            if (line_cnt_q != '0) begin
              line_cnt_d         = line_cnt_q - LEN_W'(1);
              pend_d.send_valid  = 1'b1;
              pend_d.echo_byte   = in_byte;
            end
          end else if (in_byte == CHAR_CR) begin
            state_d = ST_READY;
          end else begin
            pend_d.send_valid = 1'b1;
            pend_d.echo_byte  = in_byte;
            if (line_cnt_q < LEN_W'(LINE_DEPTH) && state_q != ST_READY) begin
              line_we    = 1'b1;
              line_cnt_d = line_cnt_q + LEN_W'(1);
              state_d    = ST_RECV;
            end else begin
              state_d = ST_READY;
            end
          end
        end
      end
      MODE_TX_DONE: begin
        if (state_q == ST_SEND) begin
          ans_pos_d = pos_inc;
          if (pos_inc < ans_len_q && pos_inc < LEN_W'(ANSWER_DEPTH)) begin
            ans_re            = 1'b1;
            pend_d.send_valid = 1'b1;
            pend_d.use_answer = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      MODE_START_ANS: begin
        ans_len_d = (in_len > LEN_W'(ANSWER_DEPTH)) ? LEN_W'(ANSWER_DEPTH) : in_len;
        ans_pos_d = '0;
        state_d   = ST_SEND;
        ans_re    = 1'b1;
        ans_raddr = '0;
        pend_d.send_valid = 1'b1;
        pend_d.use_answer = 1'b1;
      end
      MODE_WRITE_ANS: begin
        ans_we = (LEN_W'(in_idx) < LEN_W'(ANSWER_DEPTH));
      end
      MODE_READ_LINE: begin
        if (LEN_W'(in_idx) < LEN_W'(LINE_DEPTH)) begin
          line_re          = 1'b1;
          pend_d.read_line = 1'b1;
        end
      end
      MODE_SET_COUNT: begin
        line_cnt_d = (in_len > LEN_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : in_len;
      end
      default: begin
      end
    endcase

    pend_d.line_ready  = (state_d == ST_READY);
    pend_d.sending     = (state_d == ST_SEND);
    pend_d.line_length = line_cnt_d;
    line_we            = line_we && in_acc;
    line_re            = line_re && in_acc;
    ans_we             = ans_we && in_acc;
    ans_re             = ans_re && in_acc;
  end

  // control state and pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      line_cnt_q <= '0;
      ans_pos_q  <= '0;
      ans_len_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q    <= state_d;
        line_cnt_q <= line_cnt_d;
        ans_pos_q  <= ans_pos_d;
        ans_len_q  <= ans_len_d;
      end
      if (s_axis_tready_o) begin
        pend_vld_q <= in_acc;
      end
      if (pend_move) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= pend_d;
    end
    if (pend_move) begin
      out_data_q <= {7'd0,
                     pend_q.read_line ? line_rdata : 8'd0,
                     pend_q.line_length,
                     pend_q.sending,
                     pend_q.line_ready,
                     pend_q.use_answer ? ans_rdata : pend_q.echo_byte,
                     pend_q.send_valid};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // line store
  scle_ram #(
    .Width (BYTE_W),
    .Depth (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (in_byte),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // answer store
  scle_ram #(
    .Width (BYTE_W),
    .Depth (ANSWER_DEPTH)
  ) u_answer_ram (
    .clk_i   (clk_i),
    .we_i    (ans_we),
    .waddr_i (ans_waddr),
    .wdata_i (in_byte),
    .re_i    (ans_re),
    .raddr_i (ans_raddr),
    .rdata_o (ans_rdata)
  );

  // the line count never exceeds the store
  a_line_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_cnt_q <= LEN_W'(LINE_DEPTH))
    else $error("line count beyond line store");

  // the answer pointer stays within the answer while sending
  a_ans_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) |-> (ans_pos_q <= ans_len_q))
    else $error("answer position past answer length");

  // a new request never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!pend_vld_q || pend_move))
    else $error("pending result overwritten");

  // a stalled pending result stays valid and unchanged
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && !pend_move) |=> (pend_vld_q && $stable(pend_q)))
    else $error("stalled pending result changed");

endmodule

`default_nettype wire

FILE: hw/rtl/scle_ram.sv
`default_nettype none

module scle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: test/line_engine_checker.sv
`timescale 1ns / 100ps

module line_engine_checker
  import scle_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  // data_byte [7:0], entry_index [12:8], length_value [18:13], zero [23:19]
  input  logic [23:0]             s_tdata_i,
  // mode [2:0]
  input  logic [2:0]              s_tuser_i,
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  // send_valid [0], send_byte [8:1], line_ready [9], sending [10],
  // line_length [16:11], read_byte [24:17], zero [31:25]
  input  logic [31:0]             m_tdata_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output logic [LINE_DEPTH-1:0]   line_written_o,
  output logic [ANSWER_DEPTH-1:0] answer_written_o
);

  typedef struct packed {
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              line_ready;
    logic              sending;
    logic [LEN_W-1:0]  line_length;
    logic [BYTE_W-1:0] read_byte;
  } engine_status_t;

  // shadow copy of the engine
  engine_state_e     state_q;
  logic [LEN_W-1:0]  line_count_q;
  logic [LEN_W-1:0]  answer_pos_q;
  logic [LEN_W-1:0]  answer_len_q;
  logic [BYTE_W-1:0] line_mem   [LINE_DEPTH];
  logic [BYTE_W-1:0] answer_mem [ANSWER_DEPTH];

  // status words still owed by the block, oldest first
  engine_status_t status_fifo[$];

  // apply one request to the shadow and return the status it produces
  task automatic step_engine(input logic [2:0] mode, input logic [BYTE_W-1:0] data,
                             input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
                             output engine_status_t st);
    st = '0;
    case (mode)
      MODE_RX_BYTE: begin
        if (state_q != ST_SEND) begin
          if (data == CHAR_DEL) begin
            if (line_count_q != 0) begin
              line_count_q  = line_count_q - 1'b1;
              st.send_valid = 1'b1;
              st.send_byte  = data;
            end
          end else if (data == CHAR_CR) begin
            state_q = ST_READY;
          end else begin
            st.send_valid = 1'b1;
            st.send_byte  = data;
            if (line_count_q < LINE_DEPTH && state_q != ST_READY) begin
              line_mem[line_count_q]       = data;
              line_written_o[line_count_q] = 1'b1;
              line_count_q                 = line_count_q + 1'b1;
              state_q                      = ST_RECV;
            end else begin
              // overflow or typing past a finished line
              state_q = ST_READY;
            end
          end
        end
      end
      MODE_TX_DONE: begin
        if (state_q == ST_SEND) begin
          answer_pos_q = answer_pos_q + 1'b1;
          if (answer_pos_q < answer_len_q && answer_pos_q < ANSWER_DEPTH) begin
            st.send_valid = 1'b1;
            st.send_byte  = answer_mem[answer_pos_q];
          end else begin
            state_q = ST_IDLE;
          end
        end
      end
      MODE_START_ANS: begin
        answer_len_q  = (len > ANSWER_DEPTH) ? LEN_W'(ANSWER_DEPTH) : len;
        answer_pos_q  = '0;
        state_q       = ST_SEND;
        st.send_valid = 1'b1;
        st.send_byte  = answer_mem[0];
      end
      MODE_WRITE_ANS: begin
        if (idx < ANSWER_DEPTH) begin
          answer_mem[idx]       = data;
          answer_written_o[idx] = 1'b1;
        end
      end
      MODE_READ_LINE: begin
        if (idx < LINE_DEPTH) st.read_byte = line_mem[idx];
      end
      MODE_SET_COUNT: begin
        line_count_q = (len > LINE_DEPTH) ? LEN_W'(LINE_DEPTH) : len;
      end
      default: ;
    endcase
    st.line_ready  = (state_q == ST_READY);
    st.sending     = (state_q == ST_SEND);
    st.line_length = line_count_q;
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // follow both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    engine_status_t st;
    engine_status_t want;
    if (!rst_ni) begin
      state_q          = ST_IDLE;
      line_count_q     = '0;
      answer_pos_q     = '0;
      answer_len_q     = '0;
      line_written_o   = '0;
      answer_written_o = '0;
      fail_count_o     = 0;
      status_fifo.delete();
      pending_o        = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        step_engine(s_tuser_i, s_tdata_i[7:0], s_tdata_i[12:8], s_tdata_i[18:13], st);
        status_fifo.push_back(st);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (status_fifo.size() == 0) begin
          $display("%0t: unexpected result %08h", $time, m_tdata_i);
          fail_count_o++;
        end else begin
          want = status_fifo.pop_front();
          check_field("send_valid", 8'(want.send_valid), 8'(m_tdata_i[0]));
          check_field("send_byte", want.send_byte, m_tdata_i[8:1]);
          check_field("line_ready", 8'(want.line_ready), 8'(m_tdata_i[9]));
          check_field("sending", 8'(want.sending), 8'(m_tdata_i[10]));
          check_field("line_length", 8'(want.line_length), 8'(m_tdata_i[16:11]));
          check_field("read_byte", want.read_byte, m_tdata_i[24:17]);
        end
      end
      pending_o = status_fifo.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import scle_pkg::*;

  // modes the block leaves unused
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam int ITEM_TARGET = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  int                      fail_count;
  int                      pending;
  logic [LINE_DEPTH-1:0]   line_written;
  logic [ANSWER_DEPTH-1:0] answer_written;

  int burst_left = 0;
  int item_count = 0;

  serial_command_line_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  line_engine_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tuser_i        (s_tuser),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .line_written_o   (line_written),
    .answer_written_o (answer_written)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // offer one request, with burst gaps, and wait for it to be taken
  task automatic push_request(input logic [2:0] mode, input logic [7:0] data,
                              input logic [4:0] idx, input logic [5:0] len);
    int gap;
    int prefix;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    // line reads only hit entries that hold typed bytes
    if (mode == MODE_READ_LINE && !line_written[idx]) begin
      if (line_written == '0) mode = MODE_SPARE_7;
      else while (!line_written[idx]) idx = 5'($urandom_range(0, LINE_DEPTH - 1));
    end
    // an answer only covers entries already written
    if (mode == MODE_START_ANS) begin
      prefix = 0;
      while (prefix < ANSWER_DEPTH && answer_written[prefix]) prefix++;
      if (prefix == 0) begin
        mode = MODE_WRITE_ANS;
        idx  = '0;
      end else if (prefix < ANSWER_DEPTH && len > prefix) begin
        len = 6'($urandom_range(0, prefix));
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {5'b0, len, idx, data};
    item_count++;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic push_noise();
    push_request(3'($urandom_range(0, 7)), 8'($urandom), 5'($urandom), 6'($urandom));
  endtask

  // type a line, read it back, answer it and then set its count, mostly to zero
  task automatic run_session();
    int n;
    int k;
    int alen;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
    repeat (n) begin
      push_request(MODE_RX_BYTE,
                   ($urandom_range(0, 9) == 0) ? CHAR_DEL : 8'($urandom),
                   5'($urandom), 6'($urandom));
    end
    if ($urandom_range(0, 7) != 0)
      push_request(MODE_RX_BYTE, CHAR_CR, 5'($urandom), 6'($urandom));
    repeat ($urandom_range(0, 4))
      push_request(MODE_READ_LINE, 8'($urandom), 5'($urandom), 6'($urandom));
    k = ($urandom_range(0, 9) == 0) ? ANSWER_DEPTH : $urandom_range(0, 8);
    for (int i = 0; i < k; i++)
      push_request(MODE_WRITE_ANS, 8'($urandom), 5'(i), 6'($urandom));
    alen = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 10);
    push_request(MODE_START_ANS, 8'($urandom), 5'($urandom), 6'(alen));
    for (int i = 0; i <= alen && i <= ANSWER_DEPTH; i++) begin
      // typing during a send is dropped
      if ($urandom_range(0, 5) == 0)
        push_request(MODE_RX_BYTE, 8'($urandom), 5'($urandom), 6'($urandom));
      push_request(MODE_TX_DONE, 8'($urandom), 5'($urandom), 6'($urandom));
    end
    push_request(MODE_SET_COUNT, 8'($urandom), 5'($urandom),
                 ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0);
  endtask

  // result side: phases of its own plus one long hold-off
  initial begin : sink_pattern
    int style;
    int phase_len;
    int cycle_no;
    bit held_off;
    m_tready = 1'b0;
    cycle_no = 0;
    held_off = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held_off && cycle_no > 300) begin
        held_off = 1'b1;
        repeat (400) begin
          @(negedge clk_i);
          m_tready <= 1'b0;
        end
      end
      style     = $urandom_range(0, 3);
      phase_len = $urandom_range(10, 120);
      repeat (phase_len) begin
        @(negedge clk_i);
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
        cycle_no++;
      end
    end
  end

  // stimulus and verdict
  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    rst_ni   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // delete on an empty line, then a short line with edits
    push_request(MODE_RX_BYTE, CHAR_DEL, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, 8'h41, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, 8'h00, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, 8'hFF, 5'd31, 6'd63);
    push_request(MODE_RX_BYTE, CHAR_DEL, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, 8'h80, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, CHAR_CR, 5'd0, 6'd0);
    // typing and deleting on a finished line
    push_request(MODE_RX_BYTE, 8'h55, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, CHAR_DEL, 5'd0, 6'd0);
    push_request(MODE_READ_LINE, 8'h00, 5'd0, 6'd0);
    push_request(MODE_READ_LINE, 8'h00, 5'd31, 6'd0);
    push_request(MODE_READ_LINE, 8'h00, 5'd1, 6'd0);
    push_request(MODE_WRITE_ANS, 8'h00, 5'd0, 6'd0);
    push_request(MODE_WRITE_ANS, 8'hFF, 5'd31, 6'd63);
    push_request(MODE_WRITE_ANS, 8'hAA, 5'd1, 6'd0);
    // zero length answer, typing while sending, done while idle
    push_request(MODE_START_ANS, 8'h00, 5'd0, 6'd0);
    push_request(MODE_RX_BYTE, 8'h33, 5'd0, 6'd0);
    push_request(MODE_TX_DONE, 8'h00, 5'd0, 6'd0);
    push_request(MODE_TX_DONE, 8'h00, 5'd0, 6'd0);
    push_request(MODE_START_ANS, 8'h00, 5'd0, 6'd2);
    push_request(MODE_TX_DONE, 8'h00, 5'd0, 6'd0);
    push_request(MODE_TX_DONE, 8'h00, 5'd0, 6'd0);
    // saturated line count, then overflow
    push_request(MODE_SET_COUNT, 8'h00, 5'd0, 6'd63);
    push_request(MODE_RX_BYTE, 8'h31, 5'd0, 6'd0);
    push_request(MODE_SET_COUNT, 8'h00, 5'd0, 6'd0);
    push_request(MODE_SPARE_6, 8'hFF, 5'd31, 6'd63);
    push_request(MODE_SPARE_7, 8'h00, 5'd0, 6'd0);

    // mostly whole sessions, some noise
    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 10)) push_noise();
      end else begin
        run_session();
      end
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/scle_pkg.sv
hw/rtl/scle_ram.sv
hw/rtl/serial_command_line_engine.sv
test/line_engine_checker.sv
test/tb.sv
